[src/gf256_poly_mac_multi_key_stream_core_macros.svh]
// Assertion macros for the checker file of the GF(2^8) MAC core.
`ifndef GF256_POLY_MAC_MULTI_KEY_STREAM_CORE_MACROS_SVH
`define GF256_POLY_MAC_MULTI_KEY_STREAM_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GPMAC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GPMAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/gpmac_pkg.sv]
// ----------------------------------------------------------------------------
// GF(2^8) MAC package
// Shared constants, cell control struct and the GF(2^8) multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package gpmac_pkg;

  localparam int unsigned LANE_CAP = 4;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned NKEY_W   = 3;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned CFG_IX_W = 3;

  // Low byte of the reduction polynomial 0x11B.
  localparam logic [BYTE_W-1:0] POLY_LOW = 8'h1B;

  // Configuration register indexes.
  localparam logic [CFG_IX_W-1:0] REG_BLOCK_LEN = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_NUM_KEYS  = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_KEY_ZERO  = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_KEY_ONE   = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_KEY_TWO   = 3'd4;
  localparam logic [CFG_IX_W-1:0] REG_KEY_THREE = 3'd5;

  localparam logic [LEN_W-1:0]  BLOCK_LEN_RST = 16'd16;
  localparam logic [NKEY_W-1:0] NUM_KEYS_RST  = 3'd1;
  localparam logic [BYTE_W-1:0] KEY_RST       = 8'd1;

  typedef struct packed {
    logic accept;   // a data byte is taken this cycle
    logic first;    // the byte is the first of its block
    logic blk_end;  // the byte closes its block
    logic shift;    // the head of the result chain is taken this cycle
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] r;
    x = a;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        r = r ^ x;
      end
      x = x[BYTE_W-1] ? ({x[BYTE_W-2:0], 1'b0} ^ POLY_LOW) : {x[BYTE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/gpmac_cell.sv]
// ----------------------------------------------------------------------------
// GF(2^8) MAC key cell
// One key lane: accumulator and running key power, plus one stage of the
// result chain that hands finished MACs toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gpmac_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire gpmac_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic [gpmac_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic [gpmac_pkg::BYTE_W-1:0]     key_i,
  input  wire logic [gpmac_pkg::BYTE_W-1:0]     snap_next_i,
  output logic      [gpmac_pkg::BYTE_W-1:0]     snap_o
);

  logic [gpmac_pkg::BYTE_W-1:0] acc_q, acc_d;
  logic [gpmac_pkg::BYTE_W-1:0] pow_q, pow_d;
  logic [gpmac_pkg::BYTE_W-1:0] snap_q, snap_d;
  logic [gpmac_pkg::BYTE_W-1:0] pow_use;
  logic [gpmac_pkg::BYTE_W-1:0] acc_sum;

  // At block start the power restarts from the key itself.
  assign pow_use = ctrl_i.first ? key_i : pow_q;
  assign acc_sum = acc_q ^ gpmac_pkg::gf_mul(data_byte_i, pow_use);

  always_comb begin
    acc_d  = acc_q;
    pow_d  = pow_q;
    snap_d = snap_q;
    if (ctrl_i.accept) begin
      pow_d = gpmac_pkg::gf_mul(pow_use, key_i);
      acc_d = ctrl_i.blk_end ? '0 : acc_sum;
    end
    if (ctrl_i.accept && ctrl_i.blk_end) begin
      snap_d = acc_sum;
    end else if (ctrl_i.shift) begin
      snap_d = snap_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pow_q <= '0;
    end else begin
      acc_q <= acc_d;
      pow_q <= pow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_o = snap_q;

endmodule

`default_nettype wire

[src/gf256_poly_mac_multi_key_stream_core.sv]
// Latency: the first MAC of a block is shown the cycle after its closing byte beat.
// Throughput: one byte per cycle; all key cells update in parallel.
// A block-closing byte stalls while the previous block's MACs, drained one per
// cycle through the cell chain unless the output stalls, still hold more than
// the one being taken.
// Reset clears accumulators, position and counters and restores the config defaults.
// ----------------------------------------------------------------------------
// GF(2^8) multi-key polynomial MAC core
// Streams bytes through a row of key cells and drains finished MACs in key order.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_poly_mac_multi_key_stream_core #(
  parameter int unsigned MAX_KEYS = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gpmac_pkg::CFG_IX_W-1:0]    cfg_index_i,
  input  wire logic [gpmac_pkg::LEN_W-1:0]       cfg_data_i,
  // byte input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [gpmac_pkg::BYTE_W-1:0]      data_byte_i,
  input  wire logic                              end_of_stream_i,
  // MAC output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [gpmac_pkg::BYTE_W-1:0]      mac_value_o,
  output logic      [gpmac_pkg::IDX_W-1:0]       key_index_o,
  output logic                                   last_of_row_o
);

  localparam int unsigned LANES = (MAX_KEYS < gpmac_pkg::LANE_CAP) ? MAX_KEYS
                                                                   : gpmac_pkg::LANE_CAP;
  localparam int unsigned CNT_W = $clog2(LANES + 1);

  // configuration registers
  logic [gpmac_pkg::LEN_W-1:0]  block_len_q;
  logic [gpmac_pkg::NKEY_W-1:0] num_keys_q;
  logic [gpmac_pkg::BYTE_W-1:0] keys_q [gpmac_pkg::LANE_CAP];

  logic [gpmac_pkg::LEN_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [gpmac_pkg::IDX_W-1:0]  idx_q, idx_d;

  logic [gpmac_pkg::LEN_W:0]    pos_inc;
  logic [gpmac_pkg::LEN_W:0]    len_eff;
  logic [CNT_W-1:0]             active;
  logic                         blk_end;
  logic                         in_acc;
  logic                         out_acc;
  logic                         chain_free;
  gpmac_pkg::cell_ctrl_t        ctrl;
  logic [gpmac_pkg::BYTE_W-1:0] snap [LANES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_len_q <= gpmac_pkg::BLOCK_LEN_RST;
      num_keys_q  <= gpmac_pkg::NUM_KEYS_RST;
      for (int k = 0; k < gpmac_pkg::LANE_CAP; k++) begin
        keys_q[k] <= gpmac_pkg::KEY_RST;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gpmac_pkg::REG_BLOCK_LEN: block_len_q <= cfg_data_i;
        gpmac_pkg::REG_NUM_KEYS:  num_keys_q  <= cfg_data_i[gpmac_pkg::NKEY_W-1:0];
        gpmac_pkg::REG_KEY_ZERO:  keys_q[0]   <= cfg_data_i[gpmac_pkg::BYTE_W-1:0];
        gpmac_pkg::REG_KEY_ONE:   keys_q[1]   <= cfg_data_i[gpmac_pkg::BYTE_W-1:0];
        gpmac_pkg::REG_KEY_TWO:   keys_q[2]   <= cfg_data_i[gpmac_pkg::BYTE_W-1:0];
        gpmac_pkg::REG_KEY_THREE: keys_q[3]   <= cfg_data_i[gpmac_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero block length or key count acts as one; the key count is clamped to LANES.
  always_comb begin
    len_eff = (block_len_q == '0) ? (gpmac_pkg::LEN_W+1)'(1) : {1'b0, block_len_q};
    if (num_keys_q == '0) begin
      active = CNT_W'(1);
    end else if (num_keys_q > gpmac_pkg::NKEY_W'(LANES)) begin
      active = CNT_W'(LANES);
    end else begin
      active = CNT_W'(num_keys_q);
    end
  end

  assign pos_inc    = {1'b0, pos_q} + (gpmac_pkg::LEN_W+1)'(1);
  assign blk_end    = (pos_inc >= len_eff) || end_of_stream_i;
  assign out_acc    = out_valid_o && !out_stall_i;
  // The chain can take a new block once it holds at most the MAC leaving now.
  assign chain_free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_acc);
  assign in_stall_o = blk_end && !chain_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctrl.accept  = in_acc;
  assign ctrl.first   = (pos_q == '0);
  assign ctrl.blk_end = blk_end;
  assign ctrl.shift   = out_acc;

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (in_acc) begin
      pos_d = blk_end ? '0 : pos_inc[gpmac_pkg::LEN_W-1:0];
    end
    if (in_acc && blk_end) begin
      cnt_d = active;
      idx_d = '0;
    end else if (out_acc) begin
      cnt_d = cnt_q - CNT_W'(1);
      idx_d = idx_q + gpmac_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_cell
    logic [gpmac_pkg::BYTE_W-1:0] snap_next;
    if (k == LANES - 1) begin : g_tail
      assign snap_next = '0;
    end else begin : g_link
      assign snap_next = snap[k+1];
    end
    gpmac_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .data_byte_i (data_byte_i),
      .key_i       (keys_q[k]),
      .snap_next_i (snap_next),
      .snap_o      (snap[k])
    );
  end

  assign out_valid_o   = (cnt_q != '0);
  assign mac_value_o   = snap[0];
  assign key_index_o   = idx_q;
  assign last_of_row_o = (cnt_q == CNT_W'(1));

endmodule

`default_nettype wire

[src/gpmac_checker.sv]
// ----------------------------------------------------------------------------
// GF(2^8) MAC port checker
// Watches the top level's result channel for held stalled beats and key order.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf256_poly_mac_multi_key_stream_core_macros.svh"

module gpmac_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [gpmac_pkg::BYTE_W-1:0]    mac_value_o,
  input wire logic [gpmac_pkg::IDX_W-1:0]     key_index_o,
  input wire logic                            last_of_row_o
);

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  // A stalled result beat stays put.
  `GPMAC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(mac_value_o) && $stable(key_index_o), "stalled MAC beat changed")

  // Within a block the next key follows at once.
  `GPMAC_ASSERT_NEXT(a_key_step, out_acc && !last_of_row_o, out_valid_o && (key_index_o == $past(key_index_o) + 2'd1), "MAC beats of a block not in key order")

  // After the last beat of a block, any beat shown next opens a new block.
  `GPMAC_ASSERT_NEXT(a_row_restart, out_acc && last_of_row_o, !out_valid_o || (key_index_o == '0), "new block does not start at key zero")

endmodule

bind gf256_poly_mac_multi_key_stream_core gpmac_checker u_gpmac_checker (.*);

`default_nettype wire

[tb/gf256_poly_mac_multi_key_stream_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) multi-key MAC core testbench
// Drives byte beats and register writes into the core and predicts every MAC
// with a cycle-free model of the key lanes. Results are compared in order,
// under several register settings and idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
module gf256_poly_mac_multi_key_stream_core_test;

  // Index values past the register list; writes to them must be ignored.
  localparam logic [gpmac_pkg::CFG_IX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [gpmac_pkg::CFG_IX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_BYTES = 60;

  typedef struct packed {
    logic [gpmac_pkg::BYTE_W-1:0] mac;
    logic [gpmac_pkg::IDX_W-1:0]  idx;
    logic                         is_last;
  } mac_beat_t;

  class mac_scoreboard;
    logic [gpmac_pkg::LEN_W-1:0]  blk_len;
    logic [gpmac_pkg::NKEY_W-1:0] key_cnt;
    logic [gpmac_pkg::BYTE_W-1:0] key_val[gpmac_pkg::LANE_CAP];
    logic [gpmac_pkg::BYTE_W-1:0] acc[gpmac_pkg::LANE_CAP];
    logic [gpmac_pkg::BYTE_W-1:0] pw[gpmac_pkg::LANE_CAP];
    logic [gpmac_pkg::LEN_W-1:0]  pos;
    mac_beat_t                    pending[$];
    int unsigned                  errors;
    int unsigned                  checked;

    function new();
      blk_len = gpmac_pkg::BLOCK_LEN_RST;
      key_cnt = gpmac_pkg::NUM_KEYS_RST;
      for (int k = 0; k < gpmac_pkg::LANE_CAP; k++) begin
        key_val[k] = gpmac_pkg::KEY_RST;
        acc[k] = '0;
        pw[k] = '0;
      end
      pos = '0;
      errors = 0;
      checked = 0;
    endfunction

    // Horner form: walk the multiplier from its top bit, doubling as we go.
    function automatic logic [gpmac_pkg::BYTE_W-1:0] gf_times(
        logic [gpmac_pkg::BYTE_W-1:0] a, logic [gpmac_pkg::BYTE_W-1:0] b);
      logic [gpmac_pkg::BYTE_W-1:0] r;
      r = '0;
      for (int i = gpmac_pkg::BYTE_W - 1; i >= 0; i--) begin
        r = {r[gpmac_pkg::BYTE_W-2:0], 1'b0} ^
            (r[gpmac_pkg::BYTE_W-1] ? gpmac_pkg::POLY_LOW : '0);
        if (b[i]) begin
          r = r ^ a;
        end
      end
      return r;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void note_config(logic [gpmac_pkg::CFG_IX_W-1:0] idx,
                              logic [gpmac_pkg::LEN_W-1:0] val);
      case (idx)
        gpmac_pkg::REG_BLOCK_LEN: blk_len = val;
        gpmac_pkg::REG_NUM_KEYS:  key_cnt = val[gpmac_pkg::NKEY_W-1:0];
        gpmac_pkg::REG_KEY_ZERO:  key_val[0] = val[gpmac_pkg::BYTE_W-1:0];
        gpmac_pkg::REG_KEY_ONE:   key_val[1] = val[gpmac_pkg::BYTE_W-1:0];
        gpmac_pkg::REG_KEY_TWO:   key_val[2] = val[gpmac_pkg::BYTE_W-1:0];
        gpmac_pkg::REG_KEY_THREE: key_val[3] = val[gpmac_pkg::BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [gpmac_pkg::BYTE_W-1:0] b, logic eos);
      logic [gpmac_pkg::BYTE_W-1:0] p;
      int unsigned len;
      int unsigned active;
      mac_beat_t beat;
      len = (blk_len == 0) ? 1 : blk_len;
      active = (key_cnt == 0) ? 1 : key_cnt;
      if (active > gpmac_pkg::LANE_CAP) begin
        active = gpmac_pkg::LANE_CAP;
      end
      // Every lane runs, active or not, so a lane switched on mid-block is right.
      for (int k = 0; k < gpmac_pkg::LANE_CAP; k++) begin
        p = (pos == 0) ? key_val[k] : pw[k];
        acc[k] = acc[k] ^ gf_times(b, p);
        pw[k] = gf_times(p, key_val[k]);
      end
      if (int'(pos) + 1 >= len || eos) begin
        for (int k = 0; k < active; k++) begin
          beat.mac = acc[k];
          beat.idx = k[gpmac_pkg::IDX_W-1:0];
          beat.is_last = (k + 1 == active);
          pending.push_back(beat);
        end
        for (int k = 0; k < gpmac_pkg::LANE_CAP; k++) begin
          acc[k] = '0;
        end
        pos = '0;
      end else begin
        pos = pos + 1'b1;
      end
    endfunction

    task check_result(input logic [gpmac_pkg::BYTE_W-1:0] mac,
                      input logic [gpmac_pkg::IDX_W-1:0] idx,
                      input logic is_last);
      mac_beat_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected MAC %02h key %0d last %0b", mac, idx, is_last));
      end else begin
        want = pending.pop_front();
        checked++;
        if (mac !== want.mac) begin
          report($sformatf("mac_value %02h, predicted %02h (key %0d)", mac, want.mac,
                           want.idx));
        end
        if (idx !== want.idx) begin
          report($sformatf("key_index %0d, predicted %0d", idx, want.idx));
        end
        if (is_last !== want.is_last) begin
          report($sformatf("last_of_row %0b, predicted %0b (key %0d)", is_last,
                           want.is_last, want.idx));
        end
      end
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [gpmac_pkg::CFG_IX_W-1:0] cfg_index = '0;
  logic [gpmac_pkg::LEN_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [gpmac_pkg::BYTE_W-1:0]   data_byte = '0;
  logic                           end_of_stream = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [gpmac_pkg::BYTE_W-1:0]   mac_value;
  logic [gpmac_pkg::IDX_W-1:0]    key_index;
  logic                           last_of_row;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned reg_writes = 0;
  mac_scoreboard sb;

  gf256_poly_mac_multi_key_stream_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_stream_i(end_of_stream),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .mac_value_o    (mac_value),
    .key_index_o    (key_index),
    .last_of_row_o  (last_of_row)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_result(mac_value, key_index, last_of_row);
    end
  end

  // Leaves cfg_valid high so that writes can follow back to back; the caller
  // lowers it after the last one.
  task automatic write_reg(input logic [gpmac_pkg::CFG_IX_W-1:0] idx,
                           input logic [gpmac_pkg::LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.note_config(idx, val);
    reg_writes++;
  endtask

  task automatic send_byte(input logic [gpmac_pkg::BYTE_W-1:0] b, input logic eos);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_stream <= eos;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_byte(b, eos);
    bytes_sent++;
  endtask

  // A byte beat can leave no MAC, so give the core a few cycles after the
  // last MAC before touching the registers.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [gpmac_pkg::LEN_W-1:0] pick_key();
    logic [gpmac_pkg::BYTE_W-1:0] lo;
    case ($urandom_range(3))
      0: lo = 8'h00;
      1: lo = 8'hFF;
      default: lo = gpmac_pkg::BYTE_W'($urandom);
    endcase
    return {8'($urandom), lo};
  endfunction

  function automatic logic [gpmac_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return gpmac_pkg::BYTE_W'($urandom);
    endcase
  endfunction

  task automatic random_settings();
    logic [gpmac_pkg::LEN_W-1:0] len_val;
    case ($urandom_range(5))
      0: len_val = 16'd0;
      1: len_val = 16'd1;
      2: len_val = gpmac_pkg::LEN_W'($urandom_range(2, 8));
      3: len_val = gpmac_pkg::LEN_W'($urandom_range(9, 40));
      4: len_val = 16'hFFFF;
      default: len_val = gpmac_pkg::LEN_W'($urandom);
    endcase
    if ($urandom_range(3) != 0) write_reg(gpmac_pkg::REG_BLOCK_LEN, len_val);
    if ($urandom_range(3) != 0) begin
      write_reg(gpmac_pkg::REG_NUM_KEYS, gpmac_pkg::LEN_W'($urandom));
    end
    for (int k = 0; k < gpmac_pkg::LANE_CAP; k++) begin
      if ($urandom_range(3) != 0) begin
        write_reg(gpmac_pkg::CFG_IX_W'(gpmac_pkg::REG_KEY_ZERO + k), pick_key());
      end
    end
    if ($urandom_range(7) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                gpmac_pkg::LEN_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned waited;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings after reset: one key of value one, block of sixteen, closed early.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    in_valid <= 1'b0;
    drain();

    // Zero block length acts as one; all four keys, set to 00, FF, 02 and 80.
    write_reg(gpmac_pkg::REG_BLOCK_LEN, 16'd0);
    write_reg(gpmac_pkg::REG_NUM_KEYS, 16'hFFFC);
    write_reg(gpmac_pkg::REG_KEY_ZERO, 16'h5A00);
    write_reg(gpmac_pkg::REG_KEY_ONE, 16'h00FF);
    write_reg(gpmac_pkg::REG_KEY_TWO, 16'hAB02);
    write_reg(gpmac_pkg::REG_KEY_THREE, 16'h0080);
    cfg_valid <= 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
    in_valid <= 1'b0;
    drain();

    // Zero key count acts as one. The end mark on a block's last byte closes
    // it once; the phase then stops two bytes into the next block.
    write_reg(gpmac_pkg::REG_BLOCK_LEN, 16'd3);
    write_reg(gpmac_pkg::REG_NUM_KEYS, 16'd0);
    write_reg(gpmac_pkg::REG_KEY_ZERO, 16'h0053);
    cfg_valid <= 1'b0;
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    send_byte(8'hCA, 1'b0);
    send_byte(8'h00, 1'b0);
    in_valid <= 1'b0;
    drain();

    // Keys and count change inside the open block; spare indexes are ignored.
    write_reg(gpmac_pkg::REG_NUM_KEYS, 16'd7);
    write_reg(gpmac_pkg::REG_KEY_ONE, 16'h0003);
    write_reg(gpmac_pkg::REG_KEY_THREE, 16'hFFE5);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h1234);
    write_reg(gpmac_pkg::REG_BLOCK_LEN, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
    in_valid <= 1'b0;
    drain();

    write_reg(gpmac_pkg::REG_NUM_KEYS, 16'd2);
    write_reg(gpmac_pkg::REG_BLOCK_LEN, 16'd1);
    cfg_valid <= 1'b0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 60; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 60; end
        default: begin in_idle_pct = 17; out_stall_pct = 17; end
      endcase
      random_settings();
      for (int n = 0; n < PHASE_BYTES; n++) begin
        send_byte(pick_byte(), $urandom_range(9) == 0);
      end
      in_valid <= 1'b0;
      drain();
    end

    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    while (sb.pending.size() != 0) begin
      void'(sb.pending.pop_front());
      sb.report("predicted MAC never arrived");
    end

    $display("Sent %0d byte beats over %0d setting phases with %0d register writes.",
             bytes_sent, NUM_PHASES + 5, reg_writes);
    $display("Checked %0d MAC beats under mixed idle and stall; %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d MACs still outstanding.", sb.pending.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/gpmac_pkg.sv
src/gpmac_cell.sv
src/gf256_poly_mac_multi_key_stream_core.sv
src/gpmac_checker.sv
tb/gf256_poly_mac_multi_key_stream_core_test.sv
